// ===== hw/rtl/ldts_pkg.sv =====
// Package for the two-wire LED display sender: request codes, sequencer
// phases, command bytes and the digit pattern lookup. No dependencies.
package ldts_pkg;

  localparam int unsigned DefPositions     = 4;
  localparam int unsigned DefMaxBrightness = 7;

  typedef enum logic [2:0] {
    OpTick       = 3'd0,
    OpDisplayCtl = 3'd1,
    OpEnable     = 3'd2,
    OpBrightness = 3'd3,
    OpSegments   = 3'd4,
    OpDigit      = 3'd5,
    OpColon      = 3'd6,
    OpClear      = 3'd7
  } op_e;

  typedef enum logic [13:0] {
    PhIdle   = 14'b00000000000001,
    PhStart1 = 14'b00000000000010,
    PhStart2 = 14'b00000000000100,
    PhBitL   = 14'b00000000001000,
    PhBitD   = 14'b00000000010000,
    PhBitH   = 14'b00000000100000,
    PhAck1   = 14'b00000001000000,
    PhAck2   = 14'b00000010000000,
    PhAck3   = 14'b00000100000000,
    PhAck4   = 14'b00001000000000,
    PhStop1  = 14'b00010000000000,
    PhStop2  = 14'b00100000000000,
    PhStop3  = 14'b01000000000000,
    PhStop4  = 14'b10000000000000
  } phase_e;

  localparam logic [7:0] CmdDataFixed = 8'h44;
  localparam logic [7:0] CmdAddress   = 8'hC0;
  localparam logic [7:0] CmdDisplay   = 8'h80;
  localparam logic [3:0] CtlEnableBit = 4'h8;
  localparam logic [7:0] ColonBit     = 8'h80;
  localparam logic [3:0] CtlReset     = 4'hF;
  localparam logic [7:0] ColonReset   = 8'hFF;
  localparam logic [7:0] SegBlank     = 8'h00;

  // Seven-segment pattern for a decimal digit; ten and above show blank.
  function automatic logic [7:0] digit_pattern(logic [3:0] dig);
    logic [7:0] pat;
    case (dig)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h6F;
      default: pat = SegBlank;
    endcase
    return pat;
  endfunction

endpackage

// ===== hw/rtl/ldts_req_if.sv =====
// Request channel of the two-wire LED display sender: valid/ready plus
// the request and tick fields. No dependencies.
interface ldts_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [2:0] position;
  logic [7:0] segments;
  logic [3:0] digit;
  logic       enable;
  logic [3:0] brightness;
  logic       colon_on;
  logic       dio_in;

  modport source (
    output valid, op, position, segments, digit, enable, brightness, colon_on, dio_in,
    input  ready
  );
  modport sink (
    input  valid, op, position, segments, digit, enable, brightness, colon_on, dio_in,
    output ready
  );
endinterface

// ===== hw/rtl/ldts_rsp_if.sv =====
// Result channel of the two-wire LED display sender: valid/ready plus
// pin levels and status flags. No dependencies.
interface ldts_rsp_if;
  logic valid;
  logic ready;
  logic clk_res;
  logic dio_out;
  logic dio_drive;
  logic busy_res;
  logic nack;
  logic rejected;

  modport source (
    output valid, clk_res, dio_out, dio_drive, busy_res, nack, rejected,
    input  ready
  );
  modport sink (
    input  valid, clk_res, dio_out, dio_drive, busy_res, nack, rejected,
    output ready
  );
endinterface

// ===== hw/rtl/led_display_two_wire_sender_top.sv =====
// The result word for an accepted request word is valid the next cycle. One
// word per cycle is taken while results drain; the phase sequencer and pin
// registers update once per accepted word, and the result register frees as
// soon as it is taken. Reset (rst_ni low, asynchronous): sequencer idle, clock
// and data low, data driven, nack clear, display control 0xF, colon byte 0xFF,
// no result pending. Depends on ldts_pkg, ldts_req_if and ldts_rsp_if.
module led_display_two_wire_sender_top #(
  parameter int unsigned POSITIONS      = ldts_pkg::DefPositions,
  parameter int unsigned MAX_BRIGHTNESS = ldts_pkg::DefMaxBrightness
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ldts_req_if.sink  req_i,
  ldts_rsp_if.source rsp_o
);
  import ldts_pkg::*;

  localparam logic [2:0] PosMask = 3'(POSITIONS - 1);
  localparam logic [3:0] PosCount = 4'(POSITIONS);
  localparam logic [2:0] MaxLevel = 3'(MAX_BRIGHTNESS);

  // Sequencer and pin state.
  phase_e     phase_q, phase_d;
  logic [2:0] bit_idx_q, bit_idx_d;
  logic [1:0] byte_sel_q, byte_sel_d;
  logic       two_frames_q, two_frames_d;
  logic       clearing_q, clearing_d;
  logic [2:0] clear_pos_q, clear_pos_d;
  logic       clk_lvl_q, clk_lvl_d;
  logic       dio_lvl_q, dio_lvl_d;
  logic       dio_oe_q, dio_oe_d;
  logic       nack_q, nack_d;
  logic [3:0] disp_ctl_q, disp_ctl_d;
  logic [7:0] colon_q, colon_d;
  // Frame bytes: always loaded before a frame reads them, so no reset.
  logic [7:0] frame_q [3];
  logic [7:0] frame_d [3];

  // Result register.
  logic       rsp_valid_q, rsp_valid_d;
  logic       rej_q, rej_d;

  logic       accept;
  logic       busy;
  logic [7:0] cur_byte;

  assign accept      = req_i.valid && req_i.ready;
  // Take a new word whenever the result register is empty or being drained.
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign busy        = (phase_q != PhIdle);

  always_comb begin
    case (byte_sel_q)
      2'd0:    cur_byte = frame_q[0];
      2'd1:    cur_byte = frame_q[1];
      default: cur_byte = frame_q[2];
    endcase
  end

  always_comb begin
    logic [2:0] level;
    logic       en;
    logic       do_cfg;
    logic       do_seg;
    logic [2:0] seg_pos;
    logic [7:0] seg_val;
    logic [7:0] pat;
    logic [3:0] next_clear;

    phase_d      = phase_q;
    bit_idx_d    = bit_idx_q;
    byte_sel_d   = byte_sel_q;
    two_frames_d = two_frames_q;
    clearing_d   = clearing_q;
    clear_pos_d  = clear_pos_q;
    clk_lvl_d    = clk_lvl_q;
    dio_lvl_d    = dio_lvl_q;
    dio_oe_d     = dio_oe_q;
    nack_d       = nack_q;
    disp_ctl_d   = disp_ctl_q;
    colon_d      = colon_q;
    frame_d      = frame_q;
    rej_d        = 1'b0;

    level      = 3'd0;
    en         = 1'b0;
    do_cfg     = 1'b0;
    do_seg     = 1'b0;
    seg_pos    = 3'd0;
    seg_val    = SegBlank;
    pat        = SegBlank;
    next_clear = {1'b0, clear_pos_q} + 4'd1;

    if (accept) begin
      if (op_e'(req_i.op) == OpTick) begin
        // Advance the pin sequence by one step.
        unique case (phase_q)
          PhIdle: begin
          end
          PhStart1: begin
            clk_lvl_d = 1'b1;
            dio_lvl_d = 1'b1;
            dio_oe_d  = 1'b1;
            phase_d   = PhStart2;
          end
          PhStart2: begin
            dio_lvl_d = 1'b0;
            phase_d   = PhBitL;
          end
          PhBitL: begin
            clk_lvl_d = 1'b0;
            phase_d   = PhBitD;
          end
          PhBitD: begin
            dio_lvl_d = cur_byte[bit_idx_q];
            phase_d   = PhBitH;
          end
          PhBitH: begin
            clk_lvl_d = 1'b1;
            bit_idx_d = bit_idx_q + 3'd1;
            phase_d   = (bit_idx_q == 3'd7) ? PhAck1 : PhBitL;
          end
          PhAck1: begin
            clk_lvl_d = 1'b0;
            dio_oe_d  = 1'b0;
            dio_lvl_d = 1'b1;
            phase_d   = PhAck2;
          end
          PhAck2: begin
            nack_d = req_i.dio_in;
            // A high acknowledge level: drive the line low again.
            if (req_i.dio_in) begin
              dio_oe_d  = 1'b1;
              dio_lvl_d = 1'b0;
            end
            phase_d = PhAck3;
          end
          PhAck3: begin
            clk_lvl_d = 1'b1;
            phase_d   = PhAck4;
          end
          PhAck4: begin
            clk_lvl_d = 1'b0;
            dio_oe_d  = 1'b1;
            if (byte_sel_q == 2'd1) begin
              byte_sel_d = 2'd2;
              phase_d    = PhBitL;
            end else begin
              phase_d = PhStop1;
            end
          end
          PhStop1: begin
            clk_lvl_d = 1'b0;
            phase_d   = PhStop2;
          end
          PhStop2: begin
            dio_lvl_d = 1'b0;
            phase_d   = PhStop3;
          end
          PhStop3: begin
            clk_lvl_d = 1'b1;
            phase_d   = PhStop4;
          end
          PhStop4: begin
            dio_lvl_d = 1'b1;
            if (byte_sel_q == 2'd0 && two_frames_q) begin
              byte_sel_d = 2'd1;
              bit_idx_d  = 3'd0;
              phase_d    = PhStart1;
            end else if (clearing_q && next_clear < PosCount) begin
              clear_pos_d = next_clear[2:0];
              do_seg      = 1'b1;
              seg_pos     = next_clear[2:0];
              seg_val     = SegBlank;
            end else begin
              clearing_d = 1'b0;
              phase_d    = PhIdle;
            end
          end
          default: phase_d = PhIdle;
        endcase
      end else if (busy) begin
        // Drop a request that arrives mid-sequence.
        rej_d = 1'b1;
      end else begin
        unique case (op_e'(req_i.op))
          OpDisplayCtl: begin
            do_cfg = 1'b1;
            en     = req_i.enable;
            level  = (req_i.brightness > {1'b0, MaxLevel}) ? MaxLevel : req_i.brightness[2:0];
          end
          OpEnable: begin
            do_cfg = 1'b1;
            en     = req_i.enable;
            level  = disp_ctl_q[2:0] & MaxLevel;
          end
          OpBrightness: begin
            do_cfg = 1'b1;
            en     = |(disp_ctl_q & CtlEnableBit);
            level  = req_i.brightness[2:0] & MaxLevel;
          end
          OpSegments: begin
            do_seg  = 1'b1;
            seg_pos = req_i.position;
            seg_val = req_i.segments;
          end
          OpDigit: begin
            pat = digit_pattern(req_i.digit);
            // Keep the colon bit on position one.
            if (req_i.position == 3'd1) begin
              pat     = pat | (colon_q & ColonBit);
              colon_d = pat;
            end
            do_seg  = 1'b1;
            seg_pos = req_i.position;
            seg_val = pat;
          end
          OpColon: begin
            pat     = req_i.colon_on ? (colon_q | ColonBit) : (colon_q & ~ColonBit);
            colon_d = pat;
            do_seg  = 1'b1;
            seg_pos = 3'd1;
            seg_val = pat;
          end
          OpClear: begin
            clearing_d  = 1'b1;
            clear_pos_d = 3'd0;
            do_seg      = 1'b1;
            seg_pos     = 3'd0;
            seg_val     = SegBlank;
          end
          default: begin
          end
        endcase
      end
    end

    // One frame: display control byte.
    if (do_cfg) begin
      disp_ctl_d   = (en ? CtlEnableBit : 4'h0) | {1'b0, level};
      frame_d[0]   = CmdDisplay | {4'h0, (en ? CtlEnableBit : 4'h0) | {1'b0, level}};
      two_frames_d = 1'b0;
      byte_sel_d   = 2'd0;
      bit_idx_d    = 3'd0;
      phase_d      = PhStart1;
    end

    // Two frames: data command, then address and segment byte.
    if (do_seg) begin
      frame_d[0]   = CmdDataFixed;
      frame_d[1]   = CmdAddress | {5'd0, seg_pos & PosMask};
      frame_d[2]   = seg_val;
      two_frames_d = 1'b1;
      byte_sel_d   = 2'd0;
      bit_idx_d    = 3'd0;
      phase_d      = PhStart1;
    end

    // Load the result register on accept, drop it once taken.
    if (accept) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      bit_idx_q    <= 3'd0;
      byte_sel_q   <= 2'd0;
      two_frames_q <= 1'b0;
      clearing_q   <= 1'b0;
      clear_pos_q  <= 3'd0;
      clk_lvl_q    <= 1'b0;
      dio_lvl_q    <= 1'b0;
      dio_oe_q     <= 1'b1;
      nack_q       <= 1'b0;
      disp_ctl_q   <= CtlReset;
      colon_q      <= ColonReset;
      rsp_valid_q  <= 1'b0;
      rej_q        <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      bit_idx_q    <= bit_idx_d;
      byte_sel_q   <= byte_sel_d;
      two_frames_q <= two_frames_d;
      clearing_q   <= clearing_d;
      clear_pos_q  <= clear_pos_d;
      clk_lvl_q    <= clk_lvl_d;
      dio_lvl_q    <= dio_lvl_d;
      dio_oe_q     <= dio_oe_d;
      nack_q       <= nack_d;
      disp_ctl_q   <= disp_ctl_d;
      colon_q      <= colon_d;
      rsp_valid_q  <= rsp_valid_d;
      if (accept) begin
        rej_q <= rej_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

  // The pin state registers double as the result payload: they change only
  // on an accepted word, which also reloads the result register.
  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.clk_res   = clk_lvl_q;
  assign rsp_o.dio_out   = dio_lvl_q;
  assign rsp_o.dio_drive = dio_oe_q;
  assign rsp_o.busy_res  = busy;
  assign rsp_o.nack      = nack_q;
  assign rsp_o.rejected  = rej_q;

  // A rejected word leaves the sequence running.
  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rej_q) |-> busy)
    else $error("rejected word reported while idle");

  // The data line is released only inside the acknowledge slot, up to the
  // step that drives it again.
  a_release_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dio_oe_q |-> (phase_q == PhAck2 || phase_q == PhAck3 || phase_q == PhAck4))
    else $error("data line released outside acknowledge slot");

  // A clear sweep never outlives the sequence.
  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIdle) |-> !clearing_q)
    else $error("clear sweep pending while idle");

  a_byte_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_sel_q != 2'd3)
    else $error("byte select out of range");

  // A request taken while idle starts a frame.
  a_req_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.op != OpTick && phase_q == PhIdle) |=> (phase_q == PhStart1))
    else $error("request did not start a frame");

endmodule

// ===== tb/sv/led_display_two_wire_sender_top_test.sv =====
// Self-checking bench for the two-wire LED display sender: drives request and tick
// words with bursty timing and checks every result word against a local pin model.
// Depends on ldts_pkg, ldts_req_if, ldts_rsp_if and led_display_two_wire_sender_top.
module led_display_two_wire_sender_top_test;
  import ldts_pkg::*;

  localparam int unsigned Positions   = DefPositions;
  localparam int unsigned MaxBright   = DefMaxBrightness;
  localparam int unsigned TotalWords  = 1850;
  localparam int unsigned QuietLimit  = 2000;
  // Tick counts of one frame sequence: a display control frame, and a segment
  // write (data command frame followed by the address and segment frame).
  localparam int unsigned CtlTicks    = 34;
  localparam int unsigned SegTicks    = 96;

  localparam logic [7:0] DigitFont [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  typedef struct packed {
    op_e        op;
    logic [2:0] position;
    logic [7:0] segments;
    logic [3:0] digit;
    logic       enable;
    logic [3:0] brightness;
    logic       colon_on;
    logic       dio_in;
  } req_word_t;

  typedef struct packed {
    logic clk_res;
    logic dio_out;
    logic dio_drive;
    logic busy_res;
    logic nack;
    logic rejected;
  } pin_word_t;

  logic clk_i;
  logic rst_ni;

  ldts_req_if req_if ();
  ldts_rsp_if rsp_if ();

  led_display_two_wire_sender_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Pin model: its own copy of the control, colon and sequencer state.
  // ---------------------------------------------------------------------------
  logic [3:0] disp_ctl;
  logic [7:0] colon_seg;
  logic [7:0] frame_byte [3];
  phase_e     phase;
  logic [2:0] bit_idx;
  logic [2:0] clr_pos;
  logic       clk_lvl;
  logic       dio_lvl;
  logic       dio_oe;
  logic       nack_lvl;
  logic [1:0] byte_sel;
  logic       two_frames;
  logic       clearing;

  req_word_t  pending_words [$];
  pin_word_t  expected_pins [$];
  int unsigned fail_cnt;

  // Load a single display control frame; the level saturates at the top brightness.
  function automatic void load_display(logic en, logic [3:0] level);
    logic [3:0] lvl;
    lvl           = (level > MaxBright) ? 4'(MaxBright) : level;
    disp_ctl      = (en ? CtlEnableBit : 4'h0) | lvl;
    frame_byte[0] = CmdDisplay | {4'h0, disp_ctl};
    two_frames    = 1'b0;
    byte_sel      = 2'd0;
    bit_idx       = 3'd0;
    phase         = PhStart1;
  endfunction

  // Load the data command frame plus the address/segment frame.
  function automatic void load_segment_write(logic [2:0] pos, logic [7:0] seg);
    frame_byte[0] = CmdDataFixed;
    frame_byte[1] = CmdAddress | {5'h0, pos & 3'(Positions - 1)};
    frame_byte[2] = seg;
    two_frames    = 1'b1;
    byte_sel      = 2'd0;
    bit_idx       = 3'd0;
    phase         = PhStart1;
  endfunction

  // Advance the pin sequence by one tick.
  function automatic void clock_pins(logic dio_in);
    logic [7:0] cur;
    cur = frame_byte[(byte_sel > 2'd2) ? 2'd2 : byte_sel];
    case (phase)
      PhStart1: begin
        clk_lvl = 1'b1;
        dio_lvl = 1'b1;
        dio_oe  = 1'b1;
        phase   = PhStart2;
      end
      PhStart2: begin
        dio_lvl = 1'b0;
        phase   = PhBitL;
      end
      PhBitL: begin
        clk_lvl = 1'b0;
        phase   = PhBitD;
      end
      PhBitD: begin
        dio_lvl = cur[bit_idx];
        phase   = PhBitH;
      end
      PhBitH: begin
        clk_lvl = 1'b1;
        if (bit_idx == 3'd7) begin
          bit_idx = 3'd0;
          phase   = PhAck1;
        end else begin
          bit_idx = bit_idx + 3'd1;
          phase   = PhBitL;
        end
      end
      PhAck1: begin
        clk_lvl = 1'b0;
        dio_oe  = 1'b0;
        dio_lvl = 1'b1;
        phase   = PhAck2;
      end
      PhAck2: begin
        // A high level in the acknowledge slot is a nack; pull the line low then.
        nack_lvl = dio_in;
        if (dio_in) begin
          dio_oe  = 1'b1;
          dio_lvl = 1'b0;
        end
        phase = PhAck3;
      end
      PhAck3: begin
        clk_lvl = 1'b1;
        phase   = PhAck4;
      end
      PhAck4: begin
        clk_lvl = 1'b0;
        dio_oe  = 1'b1;
        // The address byte is followed by the segment byte in the same frame.
        if (byte_sel == 2'd1) begin
          byte_sel = 2'd2;
          phase    = PhBitL;
        end else begin
          phase = PhStop1;
        end
      end
      PhStop1: begin
        clk_lvl = 1'b0;
        phase   = PhStop2;
      end
      PhStop2: begin
        dio_lvl = 1'b0;
        phase   = PhStop3;
      end
      PhStop3: begin
        clk_lvl = 1'b1;
        phase   = PhStop4;
      end
      PhStop4: begin
        dio_lvl = 1'b1;
        if (byte_sel == 2'd0 && two_frames) begin
          byte_sel = 2'd1;
          bit_idx  = 3'd0;
          phase    = PhStart1;
        end else if (clearing && (int'(clr_pos) + 1 < int'(Positions))) begin
          clr_pos = clr_pos + 3'd1;
          load_segment_write(clr_pos, SegBlank);
        end else begin
          clearing = 1'b0;
          phase    = PhIdle;
        end
      end
      default: phase = PhIdle;
    endcase
  endfunction

  // Work out the result word that one accepted request or tick word causes.
  function automatic pin_word_t predict_pins(req_word_t w);
    pin_word_t  r;
    logic [7:0] pat;
    r.rejected = 1'b0;
    if (w.op == OpTick) begin
      if (phase != PhIdle) clock_pins(w.dio_in);
    end else if (phase != PhIdle) begin
      r.rejected = 1'b1;
    end else begin
      case (w.op)
        OpDisplayCtl: load_display(w.enable, w.brightness);
        OpEnable:     load_display(w.enable, disp_ctl & 4'(MaxBright));
        OpBrightness: load_display((disp_ctl & CtlEnableBit) != 4'h0,
                                   w.brightness & 4'(MaxBright));
        OpSegments:   load_segment_write(w.position, w.segments);
        OpDigit: begin
          pat = (w.digit < 4'd10) ? DigitFont[w.digit] : SegBlank;
          // Position one keeps the colon bit; compare the raw position.
          if (w.position == 3'd1) begin
            pat       = pat | (colon_seg & ColonBit);
            colon_seg = pat;
          end
          load_segment_write(w.position, pat);
        end
        OpColon: begin
          colon_seg = w.colon_on ? (colon_seg | ColonBit) : (colon_seg & ~ColonBit);
          load_segment_write(3'd1, colon_seg);
        end
        OpClear: begin
          clearing = 1'b1;
          clr_pos  = 3'd0;
          load_segment_write(3'd0, SegBlank);
        end
        default: ;
      endcase
    end
    r.clk_res   = clk_lvl;
    r.dio_out   = dio_lvl;
    r.dio_drive = dio_oe;
    r.busy_res  = (phase != PhIdle);
    r.nack      = nack_lvl;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Word generation
  // ---------------------------------------------------------------------------
  function automatic req_word_t random_word(op_e op);
    req_word_t w;
    w.op         = op;
    w.position   = 3'($urandom);
    w.segments   = 8'($urandom);
    w.digit      = 4'($urandom);
    w.enable     = 1'($urandom);
    w.brightness = 4'($urandom);
    w.colon_on   = 1'($urandom);
    w.dio_in     = 1'($urandom);
    return w;
  endfunction

  // Queue a request and the ticks that carry its whole sequence, then a few idle
  // ticks. With stray set, drop one extra request somewhere into the sequence; it
  // lands while busy and must be rejected without disturbing the pins.
  task automatic queue_transfer(req_word_t w, bit stray);
    int unsigned n;
    int unsigned stray_at;
    case (w.op)
      OpDisplayCtl, OpEnable, OpBrightness: n = CtlTicks;
      OpClear:                              n = SegTicks * Positions;
      default:                              n = SegTicks;
    endcase
    stray_at = stray ? $urandom_range(0, n - 1) : n;
    pending_words.push_back(w);
    for (int unsigned i = 0; i < n; i++) begin
      if (i == stray_at) pending_words.push_back(random_word(op_e'($urandom_range(1, 7))));
      pending_words.push_back(random_word(OpTick));
    end
    repeat ($urandom_range(0, 3)) pending_words.push_back(random_word(OpTick));
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: bursts of random length, random gaps in between.
  // ---------------------------------------------------------------------------
  req_word_t   drive_word;
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      burst_left   = 0;
      gap_left     = 0;
    end else begin
      // Predict at the handshake, in acceptance order.
      if (req_if.valid && req_if.ready) begin
        expected_pins.push_back(predict_pins(drive_word));
      end
      // Advance only when the current word is gone or none is offered.
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0 || pending_words.size() == 0) begin
          if (gap_left > 0) gap_left--;
          req_if.valid <= 1'b0;
        end else begin
          drive_word          = pending_words.pop_front();
          req_if.valid       <= 1'b1;
          req_if.op          <= drive_word.op;
          req_if.position    <= drive_word.position;
          req_if.segments    <= drive_word.segments;
          req_if.digit       <= drive_word.digit;
          req_if.enable      <= drive_word.enable;
          req_if.brightness  <= drive_word.brightness;
          req_if.colon_on    <= drive_word.colon_on;
          req_if.dio_in      <= drive_word.dio_in;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // Mostly short bursts; now and then a long stretch with no gaps.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap_left   = $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: stall on a 16-bit mask that changes when stall_phase wraps.
  // ---------------------------------------------------------------------------
  logic [15:0] stall_mask;
  logic [8:0]  stall_phase;

  function automatic void check_pin(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pin_word_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_mask   = 16'hFFFF;
      stall_phase  = '0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_pins.size() == 0) begin
          $error("result word with no request word pending");
          fail_cnt++;
        end else begin
          want = expected_pins.pop_front();
          check_pin("clk_res",   want.clk_res,   rsp_if.clk_res);
          check_pin("dio_out",   want.dio_out,   rsp_if.dio_out);
          check_pin("dio_drive", want.dio_drive, rsp_if.dio_drive);
          check_pin("busy_res",  want.busy_res,  rsp_if.busy_res);
          check_pin("nack",      want.nack,      rsp_if.nack);
          check_pin("rejected",  want.rejected,  rsp_if.rejected);
        end
      end
      stall_phase = stall_phase + 9'd1;
      if (stall_phase == '0) begin
        case ($urandom_range(0, 3))
          0:       stall_mask = 16'hFFFF;
          1:       stall_mask = 16'h5555;
          2:       stall_mask = 16'h0F0F;
          default: stall_mask = 16'($urandom) | 16'h0001;
        endcase
      end
      rsp_if.ready <= stall_mask[stall_phase[3:0]];
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when no word moves on either side for too long.
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("** led_display_two_wire_sender_top: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    req_word_t   w;
    op_e         op;

    // Hold every input at a known level from time zero.
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.op         = OpTick;
    req_if.position   = '0;
    req_if.segments   = '0;
    req_if.digit      = '0;
    req_if.enable     = 1'b0;
    req_if.brightness = '0;
    req_if.colon_on   = 1'b0;
    req_if.dio_in     = 1'b0;
    rsp_if.ready      = 1'b0;
    quiet_cycles      = 0;
    fail_cnt          = 0;

    // Model reset state.
    disp_ctl   = CtlReset;
    colon_seg  = ColonReset;
    frame_byte = '{default: 8'h00};
    phase      = PhIdle;
    bit_idx    = 3'd0;
    clr_pos    = 3'd0;
    clk_lvl    = 1'b0;
    dio_lvl    = 1'b0;
    dio_oe     = 1'b1;
    nack_lvl   = 1'b0;
    byte_sel   = 2'd0;
    two_frames = 1'b0;
    clearing   = 1'b0;

    // Directed part. Ticks while idle must leave the pins alone.
    pending_words.push_back(random_word(OpTick));
    pending_words.push_back(random_word(OpTick));
    // Display control: brightness above the top saturates; lowest level.
    w = random_word(OpDisplayCtl); w.enable = 1'b0; w.brightness = 4'hF;
    queue_transfer(w, 1'b0);
    w = random_word(OpDisplayCtl); w.enable = 1'b1; w.brightness = 4'h0;
    queue_transfer(w, 1'b0);
    // Enable only, both ways.
    w = random_word(OpEnable); w.enable = 1'b0;
    queue_transfer(w, 1'b0);
    w = random_word(OpEnable); w.enable = 1'b1;
    queue_transfer(w, 1'b0);
    // Brightness only: masked first, so 15 gives the top and 8 gives zero.
    w = random_word(OpBrightness); w.brightness = 4'hF;
    queue_transfer(w, 1'b0);
    w = random_word(OpBrightness); w.brightness = 4'h8;
    queue_transfer(w, 1'b0);
    // Raw segments at the highest position (masked) with a request while busy.
    w = random_word(OpSegments); w.position = 3'd7; w.segments = 8'hFF;
    queue_transfer(w, 1'b1);
    w = random_word(OpSegments); w.position = 3'd0; w.segments = 8'h00;
    queue_transfer(w, 1'b0);
    // Digit at position one keeps the colon; position five maps to the same
    // address but does not touch the colon; digits ten and up are blank.
    w = random_word(OpDigit); w.position = 3'd1; w.digit = 4'd8;
    queue_transfer(w, 1'b0);
    w = random_word(OpDigit); w.position = 3'd5; w.digit = 4'd15;
    queue_transfer(w, 1'b0);
    w = random_word(OpColon); w.colon_on = 1'b0;
    queue_transfer(w, 1'b0);
    w = random_word(OpDigit); w.position = 3'd1; w.digit = 4'd0;
    queue_transfer(w, 1'b0);
    w = random_word(OpColon); w.colon_on = 1'b1;
    queue_transfer(w, 1'b0);
    queue_transfer(random_word(OpClear), 1'b0);

    // Random part: mostly complete sequences with random operands, a few stray
    // requests inside them, and a little pure noise.
    while (pending_words.size() < TotalWords) begin
      if ($urandom_range(0, 99) < 3) begin
        pending_words.push_back(random_word(op_e'($urandom_range(0, 7))));
      end else begin
        op = ($urandom_range(0, 15) == 0) ? OpClear : op_e'($urandom_range(1, 6));
        queue_transfer(random_word(op), $urandom_range(0, 9) == 0);
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: everything sent, nothing outstanding, then end the run.
    while (pending_words.size() != 0 || req_if.valid || expected_pins.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("** led_display_two_wire_sender_top: PASSED **");
    end else begin
      $display("** led_display_two_wire_sender_top: FAILED **");
    end
    $finish;
  end

endmodule
